[rtl/ott_pkg.sv]
// shared types, constants and helpers for the one-shot timer table
`default_nettype none

package ott_pkg;

	localparam int NumTimers = 16;
	localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
	localparam int CntW      = $clog2(NumTimers + 1);
	localparam int SlotW     = 4;
	localparam int TickW     = 64;
	localparam int DelayW    = 32;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_ADD     = 2'd1,
		REQ_CANCEL  = 2'd2,
		REQ_RELEASE = 2'd3
	} req_e;

	typedef enum logic [1:0] {
		EV_ACK       = 2'd0,
		EV_EXPIRED   = 2'd1,
		EV_FULL      = 2'd2,
		EV_BADHANDLE = 2'd3
	} ev_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACK,
		ST_ADD,
		ST_RD,
		ST_MOD
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [DelayW-1:0] delay;
		logic [SlotW-1:0]  timer_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]       event_res;
		logic [SlotW-1:0] slot;
		logic [TickW-1:0] now_tick;
		logic             wrap_flag;
		logic             last;
	} rsp_t;

	// one stored timer entry
	typedef struct packed {
		logic [TickW-1:0] expiry;
		logic             fired;
		logic             held;
	} entry_t;

	function automatic logic [SlotW-1:0] to_slot(input logic [IdxW-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[SlotW-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/one_shot_timer_table.sv]
// one-shot timer table: controller, tick counter, live flags and timer entry ram
//
//  channel | valid     | stall     | payload        | transfer when
//  --------+-----------+-----------+----------------+---------------------------
//  request | req_valid | req_stall | req (req_t)    | req_valid && !req_stall
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)    | rsp_valid && !rsp_stall
//
// one request at a time. on a tick the scan reads one ram entry per cycle, while
// not held, through the single read port and checks it the cycle after. add
// writes the new entry; cancel and release read the entry, then write it back.
// a stalled result channel holds the scan in place; one result waits in the
// output register while the next is worked out. reset clears the counter and
// live flags; the ram needs no clearing since entries are used only when live.
`default_nettype none

module one_shot_timer_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ott_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ott_pkg::rsp_t      rsp
);

	ott_pkg::state_t                     state_q, state_d;
	logic [ott_pkg::TickW-1:0]           tick_q;
	logic [ott_pkg::NumTimers-1:0]       in_use_q;
	ott_pkg::req_t                       req_q;
	logic [ott_pkg::CntW-1:0]            rd_idx_q;
	logic                                v_s1;
	logic [ott_pkg::IdxW-1:0]            idx_s1;

	logic                                accept;
	logic                                out_ready;
	logic                                push;
	ott_pkg::rsp_t                       push_data;

	logic                                ram_we, ram_re;
	logic [ott_pkg::IdxW-1:0]            ram_waddr, ram_raddr;
	ott_pkg::entry_t                     ram_wdata, ram_rdata;

	logic                                rd_more, live, fire, scan_hold, free_s1, scan_done;
	logic                                any_free;
	logic [ott_pkg::IdxW-1:0]            free_idx;
	logic [ott_pkg::TickW:0]             add_sum;
	logic [ott_pkg::IdxW-1:0]            hs_idx;
	logic                                handle_ok;
	logic                                set_use, clr_use;
	logic [ott_pkg::IdxW-1:0]            use_idx;

	assign req_stall = (state_q != ott_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;

	// scan stage: entry idx_s1 is in ram_rdata
	assign rd_more   = (rd_idx_q < ott_pkg::CntW'(ott_pkg::NumTimers));
	assign live      = v_s1 && in_use_q[idx_s1];
	assign fire      = live && !ram_rdata.fired && (ram_rdata.expiry < tick_q);
	assign scan_hold = fire && !out_ready;
	assign free_s1   = live && (ram_rdata.fired || fire) && !ram_rdata.held && !scan_hold;
	assign scan_done = !rd_more && !scan_hold;

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = ott_pkg::NumTimers - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				any_free = 1'b1;
				free_idx = ott_pkg::IdxW'(i);
			end
		end
	end

	assign add_sum   = {1'b0, tick_q} + {{(ott_pkg::TickW - ott_pkg::DelayW + 1){1'b0}}, req_q.delay};
	assign hs_idx    = ott_pkg::IdxW'(req_q.timer_slot);
	assign handle_ok = (32'(req_q.timer_slot) < 32'(ott_pkg::NumTimers)) && in_use_q[hs_idx];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ott_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						ott_pkg::REQ_TICK: state_d = ott_pkg::ST_SCAN;
						ott_pkg::REQ_ADD:  state_d = ott_pkg::ST_ADD;
						default:           state_d = ott_pkg::ST_RD;
					endcase
				end
			end
			ott_pkg::ST_SCAN: if (scan_done) state_d = ott_pkg::ST_ACK;
			ott_pkg::ST_ACK:  if (out_ready) state_d = ott_pkg::ST_IDLE;
			ott_pkg::ST_ADD:  if (out_ready) state_d = ott_pkg::ST_IDLE;
			ott_pkg::ST_RD:   state_d = ott_pkg::ST_MOD;
			ott_pkg::ST_MOD:  if (out_ready) state_d = ott_pkg::ST_IDLE;
			default:          state_d = ott_pkg::ST_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		push                = 1'b0;
		push_data.event_res = ott_pkg::EV_ACK;
		push_data.slot      = '0;
		push_data.now_tick  = tick_q;
		push_data.wrap_flag = 1'b0;
		push_data.last      = 1'b1;
		ram_we              = 1'b0;
		ram_waddr           = idx_s1;
		ram_wdata.expiry    = ram_rdata.expiry;
		ram_wdata.fired     = 1'b1;
		ram_wdata.held      = ram_rdata.held;
		ram_re              = 1'b0;
		ram_raddr           = rd_idx_q[ott_pkg::IdxW-1:0];
		set_use             = 1'b0;
		clr_use             = 1'b0;
		use_idx             = idx_s1;
		unique case (state_q)
			ott_pkg::ST_IDLE: ;
			ott_pkg::ST_SCAN: begin
				ram_re              = rd_more && !scan_hold;
				push                = fire && out_ready;
				push_data.event_res = ott_pkg::EV_EXPIRED;
				push_data.slot      = ott_pkg::to_slot(idx_s1);
				push_data.last      = 1'b0;
				ram_we              = fire && out_ready;
				clr_use             = free_s1;
			end
			ott_pkg::ST_ACK: begin
				push = 1'b1;
			end
			ott_pkg::ST_ADD: begin
				push = 1'b1;
				if (any_free) begin
					push_data.slot      = ott_pkg::to_slot(free_idx);
					push_data.wrap_flag = add_sum[ott_pkg::TickW];
					ram_we              = out_ready;
					ram_waddr           = free_idx;
					ram_wdata.expiry    = add_sum[ott_pkg::TickW-1:0];
					ram_wdata.fired     = 1'b0;
					ram_wdata.held      = 1'b1;
					set_use             = out_ready;
					use_idx             = free_idx;
				end else begin
					push_data.event_res = ott_pkg::EV_FULL;
				end
			end
			ott_pkg::ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = hs_idx;
			end
			ott_pkg::ST_MOD: begin
				push           = 1'b1;
				push_data.slot = req_q.timer_slot;
				if (handle_ok) begin
					ram_we          = out_ready;
					ram_waddr       = hs_idx;
					ram_wdata.fired = ram_rdata.fired || (req_q.req_type == ott_pkg::REQ_CANCEL);
					ram_wdata.held  = 1'b0;
				end else begin
					push_data.event_res = ott_pkg::EV_BADHANDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ott_pkg::ST_IDLE;
			tick_q   <= '0;
			in_use_q <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rd_idx_q <= '0;
				v_s1     <= 1'b0;
				if (req.req_type == ott_pkg::REQ_TICK) begin
					tick_q <= tick_q + ott_pkg::TickW'(1);
				end
			end else if (state_q == ott_pkg::ST_SCAN && !scan_hold) begin
				v_s1 <= rd_more;
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + ott_pkg::CntW'(1);
				end
			end
			if (set_use) begin
				in_use_q[use_idx] <= 1'b1;
			end else if (clr_use) begin
				in_use_q[use_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ott_pkg::ST_SCAN && !scan_hold) begin
			idx_s1 <= rd_idx_q[ott_pkg::IdxW-1:0];
		end
	end

	ott_ram #(
		.Depth(ott_pkg::NumTimers),
		.Width($bits(ott_pkg::entry_t))
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ott_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_data),
		.ready     (out_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[rtl/ott_ram.sv]
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none

module ott_ram #(
	parameter int Depth = 16,
	parameter int Width = 66,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/ott_out_buf.sv]
// result output register between the controller and the result channel
`default_nettype none

module ott_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ott_pkg::rsp_t din,
	output logic               ready,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ott_pkg::rsp_t      rsp
);

	logic          valid_q;
	ott_pkg::rsp_t data_q;

	assign ready     = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && ready) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && ready) begin
			data_q <= din;
		end
	end

endmodule

`default_nettype wire
